@@ rtl/core/stza_pkg.sv @@
// ----------------------------------------------------------------------------
// stza_pkg
// shared types and constants of the slot table zone allocator
// ----------------------------------------------------------------------------
package stza_pkg;

	localparam int unsigned SIZE_W = 19;
	localparam int unsigned SLOT_W = 8;
	localparam int unsigned ALU_W  = SIZE_W + 1;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 3;

	localparam logic [SIZE_W-1:0] ZONE_RESET = 19'd409600;
	localparam logic [SIZE_W-1:0] SIZE_MAX   = 19'h7FFFF;

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	// register select bit of paddr (register 0 is zone_bytes)
	localparam logic REG_ZONE_BYTES = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_BUMP_OFF,
		ST_BUMP_REM,
		ST_FINISH
	} state_t;

	// write controls of the slot memory, one address for all fields
	typedef struct packed {
		logic              rel_we;
		logic              bytes_we;
		logic              start_we;
		logic              rel_d;
		logic [SIZE_W-1:0] bytes_d;
		logic [SIZE_W-1:0] start_d;
	} slot_wr_t;

	// one slot entry as read back
	typedef struct packed {
		logic              rel;
		logic [SIZE_W-1:0] bytes;
		logic [SIZE_W-1:0] start;
	} slot_entry_t;

endpackage

@@ rtl/core/stza_if.sv @@
// ----------------------------------------------------------------------------
// stza_in_if / stza_out_if
// valid/ready channels for request and result items
// ----------------------------------------------------------------------------
interface stza_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [stza_pkg::SIZE_W-1:0] request_size;
	logic [stza_pkg::SLOT_W-1:0] release_slot;

	modport source (output valid, mode, request_size, release_slot, input ready);
	modport sink   (input valid, mode, request_size, release_slot, output ready);
endinterface

interface stza_out_if;
	logic                        valid;
	logic                        ready;
	logic [stza_pkg::SLOT_W-1:0] slot_number;
	logic [stza_pkg::SIZE_W-1:0] byte_offset;
	logic                        reused_slot;
	logic                        fresh_zone;

	modport source (output valid, slot_number, byte_offset, reused_slot, fresh_zone,
		input ready);
	modport sink   (input valid, slot_number, byte_offset, reused_slot, fresh_zone,
		output ready);
endinterface

@@ rtl/core/slot_table_zone_allocator.sv @@
// ----------------------------------------------------------------------------
// slot_table_zone_allocator: first-fit slot reuse with bump allocation in one zone
// release item: taken on accept, no result; allocate item: the N slots in use are scanned one per
// cycle, N slots in use after any fresh zone, at most SLOT_COUNT-1; a fitting released slot ends
// the scan, else the bump steps follow; a new item is taken only once the result is registered
// reset: zone_bytes and remaining bytes to 409600, no slot in use, no clearing pass needed
// ----------------------------------------------------------------------------
module slot_table_zone_allocator #(
	parameter int unsigned SLOT_COUNT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	stza_in_if.sink                       alloc_in,
	stza_out_if.source                    alloc_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [stza_pkg::ADDR_W-1:0]   paddr,
	input  logic [stza_pkg::DATA_W-1:0]   pwdata,
	output logic [stza_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int unsigned IW = $clog2(SLOT_COUNT);      // slot address bits
	localparam int unsigned UW = $clog2(SLOT_COUNT + 1);  // count bits, holds SLOT_COUNT
	localparam logic [UW-1:0] SLOT_FULL = UW'(SLOT_COUNT);

	// configuration
	logic [stza_pkg::SIZE_W-1:0] zone_q;

	// zone state; slots in use always form a prefix, so a count replaces the flags
	logic [stza_pkg::SIZE_W-1:0] rem_q;
	logic [UW-1:0]               used_q;

	// sequencer and per-item registers
	stza_pkg::state_t            state_q, state_d;
	logic [stza_pkg::SIZE_W-1:0] req_q;
	logic                        fresh_q;
	logic [UW-1:0]               k_q;      // next slot to read
	logic [IW-1:0]               cmp_k_q;  // slot whose entry is on the read port
	logic                        pend_q;   // read data valid for compare
	logic [stza_pkg::SIZE_W-1:0] off_q;
	logic [stza_pkg::SLOT_W-1:0] res_slot_q;
	logic [stza_pkg::SIZE_W-1:0] res_off_q;
	logic                        res_reused_q;

	// output register
	logic                        out_valid_q;
	logic [stza_pkg::SLOT_W-1:0] out_slot_q;
	logic [stza_pkg::SIZE_W-1:0] out_off_q;
	logic                        out_reused_q;
	logic                        out_fresh_q;

	// shared subtractor
	logic [stza_pkg::ALU_W-1:0]  alu_a, alu_b, alu_diff;
	logic                        alu_borrow;

	// slot memory
	stza_pkg::slot_wr_t          wr;
	logic [IW-1:0]               wr_addr;
	logic                        rd_en;
	stza_pkg::slot_entry_t       rd_data;

	logic in_acc, alloc_acc, release_acc, release_ok;
	logic full, hit, scan_end, out_free;
	logic [stza_pkg::ALU_W-1:0]  off_inc;

	stza_alu u_alu (
		.a        (alu_a),
		.b        (alu_b),
		.diff_sat (alu_diff),
		.borrow   (alu_borrow)
	);

	stza_slot_mem #(.DEPTH(SLOT_COUNT)) u_mem (
		.clk     (clk),
		.wr_addr (wr_addr),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (k_q[IW-1:0]),
		.rd_data (rd_data)
	);

	// apb register port, write on the access cycle
	assign pready = 1'b1;
	assign prdata = (paddr[2] == stza_pkg::REG_ZONE_BYTES)
		? stza_pkg::DATA_W'(zone_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= stza_pkg::ZONE_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == stza_pkg::REG_ZONE_BYTES) begin
			zone_q <= pwdata[stza_pkg::SIZE_W-1:0];
		end
	end

	// handshake and decode
	assign alloc_in.ready = (state_q == stza_pkg::ST_IDLE);
	assign in_acc         = alloc_in.valid && alloc_in.ready;
	assign alloc_acc      = in_acc && alloc_in.mode == stza_pkg::MODE_ALLOC;
	assign release_acc    = in_acc && alloc_in.mode == stza_pkg::MODE_RELEASE;
	// slots at or past the fill count are not in use, which covers out-of-table numbers
	assign release_ok     = 32'(alloc_in.release_slot) < 32'(used_q);

	// alu in idle: remaining minus request, borrow means the zone is too small
	assign full     = alu_borrow || used_q == SLOT_FULL;
	// alu in scan: recorded size minus request, no borrow means it fits
	assign hit      = pend_q && rd_data.rel && !alu_borrow;
	assign scan_end = k_q >= used_q;
	assign out_free = !out_valid_q || alloc_out.ready;
	assign off_inc  = alu_diff + stza_pkg::ALU_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			stza_pkg::ST_IDLE: begin
				if (alloc_acc) state_d = stza_pkg::ST_SCAN;
			end
			stza_pkg::ST_SCAN: begin
				if (hit) state_d = stza_pkg::ST_FINISH;
				else if (scan_end) state_d = stza_pkg::ST_BUMP_OFF;
			end
			stza_pkg::ST_BUMP_OFF: state_d = stza_pkg::ST_BUMP_REM;
			stza_pkg::ST_BUMP_REM: state_d = stza_pkg::ST_FINISH;
			stza_pkg::ST_FINISH: begin
				if (out_free) state_d = stza_pkg::ST_IDLE;
			end
			default: state_d = stza_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: alu operands and memory controls
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		wr      = '0;
		wr_addr = '0;
		rd_en   = 1'b0;
		case (state_q)
			stza_pkg::ST_IDLE: begin
				alu_a = stza_pkg::ALU_W'(rem_q);
				alu_b = stza_pkg::ALU_W'(alloc_in.request_size);
				if (release_acc && release_ok) begin
					wr.rel_we = 1'b1;
					wr.rel_d  = 1'b1;
					wr_addr   = IW'(alloc_in.release_slot);
				end
			end
			stza_pkg::ST_SCAN: begin
				alu_a = stza_pkg::ALU_W'(rd_data.bytes);
				alu_b = stza_pkg::ALU_W'(req_q);
				rd_en = !scan_end;
				if (hit) begin
					// reused slot: clear released, size shrinks to the request
					wr.rel_we   = 1'b1;
					wr.rel_d    = 1'b0;
					wr.bytes_we = 1'b1;
					wr.bytes_d  = req_q;
					wr_addr     = cmp_k_q;
				end
			end
			stza_pkg::ST_BUMP_OFF: begin
				// bytes taken so far
				alu_a = stza_pkg::ALU_W'(zone_q);
				alu_b = stza_pkg::ALU_W'(rem_q);
			end
			stza_pkg::ST_BUMP_REM: begin
				// remaining minus request plus the gap byte
				alu_a = stza_pkg::ALU_W'(rem_q);
				alu_b = stza_pkg::ALU_W'(req_q) + stza_pkg::ALU_W'(1);
				wr.rel_we   = 1'b1;
				wr.rel_d    = 1'b0;
				wr.bytes_we = 1'b1;
				wr.bytes_d  = req_q;
				wr.start_we = 1'b1;
				wr.start_d  = off_q;
				wr_addr     = used_q[IW-1:0];
			end
			stza_pkg::ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stza_pkg::ST_IDLE;
			rem_q       <= stza_pkg::ZONE_RESET;
			used_q      <= '0;
			k_q         <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				stza_pkg::ST_IDLE: begin
					if (alloc_acc) begin
						k_q    <= '0;
						pend_q <= 1'b0;
						if (full) begin
							// fresh zone: empty table, reload capacity
							rem_q  <= zone_q;
							used_q <= '0;
						end
					end
				end
				stza_pkg::ST_SCAN: begin
					if (!hit && !scan_end) begin
						k_q    <= k_q + UW'(1);
						pend_q <= 1'b1;
					end
				end
				stza_pkg::ST_BUMP_REM: begin
					rem_q  <= alu_diff[stza_pkg::SIZE_W-1:0];
					used_q <= used_q + UW'(1);
				end
				default: begin
				end
			endcase
			if (state_q == stza_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (alloc_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			stza_pkg::ST_IDLE: begin
				if (alloc_acc) begin
					req_q   <= alloc_in.request_size;
					fresh_q <= full;
				end
			end
			stza_pkg::ST_SCAN: begin
				cmp_k_q <= k_q[IW-1:0];
				if (hit) begin
					res_slot_q   <= stza_pkg::SLOT_W'(cmp_k_q);
					res_off_q    <= rd_data.start;
					res_reused_q <= 1'b1;
				end
			end
			stza_pkg::ST_BUMP_OFF: begin
				// first block of a zone at 0, later ones after a one-byte gap
				if (rem_q == zone_q) begin
					off_q <= '0;
				end else if (off_inc[stza_pkg::SIZE_W]) begin
					off_q <= stza_pkg::SIZE_MAX;
				end else begin
					off_q <= off_inc[stza_pkg::SIZE_W-1:0];
				end
			end
			stza_pkg::ST_BUMP_REM: begin
				res_slot_q   <= stza_pkg::SLOT_W'(used_q);
				res_off_q    <= off_q;
				res_reused_q <= 1'b0;
			end
			default: begin
			end
		endcase
		if (state_q == stza_pkg::ST_FINISH && out_free) begin
			out_slot_q   <= res_slot_q;
			out_off_q    <= res_off_q;
			out_reused_q <= res_reused_q;
			out_fresh_q  <= fresh_q;
		end
	end

	assign alloc_out.valid       = out_valid_q;
	assign alloc_out.slot_number = out_slot_q;
	assign alloc_out.byte_offset = out_off_q;
	assign alloc_out.reused_slot = out_reused_q;
	assign alloc_out.fresh_zone  = out_fresh_q;

`ifndef SYNTHESIS
	// the fill count never passes the table size
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= 32'(SLOT_COUNT))
		else $error("slot fill count beyond table");

	// a bump write always lands on a free slot
	a_bump_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == stza_pkg::ST_BUMP_REM |-> used_q < SLOT_FULL)
		else $error("bump allocation into a full table");

	// compared entries are always slots in use
	a_cmp_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stza_pkg::ST_SCAN && pend_q) |-> 32'(cmp_k_q) < 32'(used_q))
		else $error("scan compared a slot not in use");

	// a new result only comes out of the finish step
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == stza_pkg::ST_FINISH)
		else $error("result item without finish step");
`endif

endmodule

@@ rtl/core/stza_alu.sv @@
// ----------------------------------------------------------------------------
// stza_alu
// shared subtractor with borrow and zero-saturated difference
// ----------------------------------------------------------------------------
module stza_alu (
	input  logic [stza_pkg::ALU_W-1:0] a,
	input  logic [stza_pkg::ALU_W-1:0] b,
	output logic [stza_pkg::ALU_W-1:0] diff_sat,
	output logic                       borrow
);

	logic [stza_pkg::ALU_W:0] diff;

	assign diff     = {1'b0, a} - {1'b0, b};
	assign borrow   = diff[stza_pkg::ALU_W];
	assign diff_sat = borrow ? '0 : diff[stza_pkg::ALU_W-1:0];

endmodule

@@ rtl/core/stza_slot_mem.sv @@
// ----------------------------------------------------------------------------
// stza_slot_mem
// per-slot released flag, size and start offset, one write and one read port
// ----------------------------------------------------------------------------
module stza_slot_mem #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                      clk,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  stza_pkg::slot_wr_t        wr,
	input  logic                      rd_en,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output stza_pkg::slot_entry_t     rd_data
);

	logic                        rel_mem   [DEPTH];
	logic [stza_pkg::SIZE_W-1:0] bytes_mem [DEPTH];
	logic [stza_pkg::SIZE_W-1:0] start_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.rel_we) begin
			rel_mem[wr_addr] <= wr.rel_d;
		end
		if (wr.bytes_we) begin
			bytes_mem[wr_addr] <= wr.bytes_d;
		end
		if (wr.start_we) begin
			start_mem[wr_addr] <= wr.start_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data.rel   <= rel_mem[rd_addr];
			rd_data.bytes <= bytes_mem[rd_addr];
			rd_data.start <= start_mem[rd_addr];
		end
	end

endmodule

@@ test/stza_checker.sv @@
// ----------------------------------------------------------------------------
// stza_checker
// watches the request, result and register channels of the allocator, keeps a
// model of its slot table and zone, and compares every result with the model
// ----------------------------------------------------------------------------
module stza_checker #(
	parameter int unsigned SLOT_COUNT = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	stza_in_if                          in_ch,
	stza_out_if                         out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [stza_pkg::ADDR_W-1:0] paddr,
	input  logic [stza_pkg::DATA_W-1:0] pwdata,
	output int unsigned                 fail_count,
	output int unsigned                 outstanding,
	output int unsigned                 allocs_checked,
	output int unsigned                 reuses_seen,
	output int unsigned                 fresh_seen
);
	import stza_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_number;
		logic [SIZE_W-1:0] byte_offset;
		logic              reused_slot;
		logic              fresh_zone;
	} grant_t;

	logic [SIZE_W-1:0] zone_size;
	logic [SIZE_W-1:0] bytes_left;
	bit                in_use [SLOT_COUNT];
	bit                freed [SLOT_COUNT];
	logic [SIZE_W-1:0] held_bytes [SLOT_COUNT];
	logic [SIZE_W-1:0] held_start [SLOT_COUNT];
	grant_t            grants_due [$];

	function automatic void open_zone();
		for (int k = 0; k < SLOT_COUNT; k++) begin
			in_use[k] = 1'b0;
			freed[k]  = 1'b0;
		end
		bytes_left = zone_size;
	endfunction

	function automatic grant_t grant_for(input logic [SIZE_W-1:0] req);
		grant_t           g;
		int unsigned      next_free;
		logic [ALU_W-1:0] taken;
		logic [ALU_W-1:0] offset;
		logic [ALU_W-1:0] cost;
		next_free = 0;
		while (next_free < SLOT_COUNT && in_use[next_free])
			next_free++;
		g.fresh_zone = 1'b0;
		// out of bytes or out of slots: start over in a fresh zone
		if (bytes_left < req || next_free >= SLOT_COUNT) begin
			open_zone();
			g.fresh_zone = 1'b1;
			next_free = 0;
		end
		// first fit among released slots
		for (int k = 0; k < next_free; k++) begin
			if (freed[k] && req <= held_bytes[k]) begin
				freed[k]      = 1'b0;
				held_bytes[k] = req;
				g.slot_number = SLOT_W'(k);
				g.byte_offset = held_start[k];
				g.reused_slot = 1'b1;
				return g;
			end
		end
		// bump allocation, one spare byte between blocks
		if (bytes_left == zone_size) begin
			offset = '0;
		end else begin
			taken  = (zone_size > bytes_left) ? ALU_W'(zone_size - bytes_left) : '0;
			offset = taken + 1'b1;
			if (offset > ALU_W'(SIZE_MAX))
				offset = ALU_W'(SIZE_MAX);
		end
		in_use[next_free]     = 1'b1;
		freed[next_free]      = 1'b0;
		held_bytes[next_free] = req;
		held_start[next_free] = offset[SIZE_W-1:0];
		cost = ALU_W'(req) + 1'b1;
		bytes_left = (ALU_W'(bytes_left) > cost) ? bytes_left - cost[SIZE_W-1:0] : '0;
		g.slot_number = SLOT_W'(next_free);
		g.byte_offset = offset[SIZE_W-1:0];
		g.reused_slot = 1'b0;
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			zone_size = ZONE_RESET;
			open_zone();
			grants_due.delete();
			fail_count     = 0;
			allocs_checked = 0;
			reuses_seen    = 0;
			fresh_seen     = 0;
			outstanding <= 0;
		end else begin
			// results first: they always belong to earlier requests
			if (out_ch.valid && out_ch.ready) begin
				if (grants_due.size() == 0) begin
					$error("unexpected result: slot_number %0d byte_offset %0d",
						out_ch.slot_number, out_ch.byte_offset);
					fail_count++;
				end else begin
					want = grants_due.pop_front();
					allocs_checked++;
					if (want.reused_slot) reuses_seen++;
					if (want.fresh_zone) fresh_seen++;
					if (out_ch.slot_number !== want.slot_number) begin
						$error("slot_number: expected %0d, actual %0d",
							want.slot_number, out_ch.slot_number);
						fail_count++;
					end
					if (out_ch.byte_offset !== want.byte_offset) begin
						$error("byte_offset: expected %0d, actual %0d",
							want.byte_offset, out_ch.byte_offset);
						fail_count++;
					end
					if (out_ch.reused_slot !== want.reused_slot) begin
						$error("reused_slot: expected %0b, actual %0b",
							want.reused_slot, out_ch.reused_slot);
						fail_count++;
					end
					if (out_ch.fresh_zone !== want.fresh_zone) begin
						$error("fresh_zone: expected %0b, actual %0b",
							want.fresh_zone, out_ch.fresh_zone);
						fail_count++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.mode == MODE_RELEASE) begin
					if (in_ch.release_slot < SLOT_COUNT && in_use[in_ch.release_slot])
						freed[in_ch.release_slot] = 1'b1;
				end else begin
					grants_due.push_back(grant_for(in_ch.request_size));
				end
			end
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == REG_ZONE_BYTES)
				zone_size = pwdata[SIZE_W-1:0];
			outstanding <= grants_due.size();
		end
	end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// stimulus for the slot table zone allocator: a directed opening, then phases
// of random allocate and release traffic under several zone sizes and
// handshake stall patterns; stza_checker predicts and compares all results
// ----------------------------------------------------------------------------
module tb;
	import stza_pkg::*;

	localparam int unsigned SLOT_COUNT   = 256;
	localparam int unsigned CYCLE_LIMIT  = 3_000_000;
	localparam int unsigned PHASE_ITEMS  = 270;
	localparam int unsigned PHASES       = 6;
	localparam int unsigned FILL_ITEMS   = 300;
	// a release gives no result, an allocation scans every slot in use
	localparam int unsigned QUIET_CYCLES = 16;
	localparam int unsigned DRAIN_CYCLES = SLOT_COUNT + 40;
	localparam logic [ADDR_W-1:0] ZONE_ADDR = ADDR_W'({REG_ZONE_BYTES, 2'b00});

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	stza_in_if  in_ch ();
	stza_out_if out_ch ();

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned allocs_checked;
	int unsigned reuses_seen;
	int unsigned fresh_seen;

	int unsigned       cycles = 0;
	int unsigned       tx_idle;
	int unsigned       rx_idle;
	int unsigned       items_sent;
	logic [SIZE_W-1:0] zone_setting;
	logic [SLOT_W-1:0] last_slot = '0;

	slot_table_zone_allocator #(
		.SLOT_COUNT(SLOT_COUNT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.alloc_in (in_ch),
		.alloc_out(out_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	stza_checker #(
		.SLOT_COUNT(SLOT_COUNT)
	) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.allocs_checked(allocs_checked),
		.reuses_seen   (reuses_seen),
		.fresh_seen    (fresh_seen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d allocations still due", cycles, outstanding);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side stalls at random, rate set per phase
	always @(posedge clk)
		out_ch.ready <= ($urandom_range(0, 99) >= rx_idle);

	// most recent slot handed out, steers releases toward live slots
	always @(posedge clk)
		if (out_ch.valid && out_ch.ready)
			last_slot <= out_ch.slot_number;

	// present one item, return at the edge where it is taken
	task automatic send_item(input logic mode, input logic [SIZE_W-1:0] size,
		input logic [SLOT_W-1:0] slot);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.mode         <= mode;
		in_ch.request_size <= size;
		in_ch.release_slot <= slot;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	// fill runs: small allocations that use up every slot of a zone
	// mixed runs: releases, small to huge sizes, byte exhaustion
	task automatic send_run(input int unsigned count, input bit fill);
		logic              mode;
		logic [SIZE_W-1:0] size;
		logic [SLOT_W-1:0] slot;
		int unsigned       pick;
		repeat (count) begin
			if (fill) begin
				mode = ($urandom_range(0, 99) < 5) ? MODE_RELEASE : MODE_ALLOC;
				size = SIZE_W'($urandom_range(0, 15));
			end else begin
				mode = ($urandom_range(0, 99) < 25) ? MODE_RELEASE : MODE_ALLOC;
				pick = $urandom_range(0, 99);
				if (pick < 70)
					size = SIZE_W'($urandom_range(0, 63));
				else if (pick < 85)
					size = SIZE_W'($urandom_range(64, 4095));
				else if (pick < 95)
					size = SIZE_W'($urandom_range(0, zone_setting));
				else
					size = SIZE_W'($urandom_range(0, SIZE_MAX));
			end
			// mostly live slots, sometimes anything at all
			if ($urandom_range(0, 3) == 0)
				slot = SLOT_W'($urandom_range(0, 255));
			else
				slot = SLOT_W'($urandom_range(0, last_slot));
			send_item(mode, size, slot);
		end
	endtask

	// stop sending, wait out every pending result, then let the block go idle
	task automatic wait_idle(input int unsigned extra);
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (extra) @(posedge clk);
	endtask

	// setup then access cycle; upper bits of the bus carry junk
	task automatic write_zone_bytes(input logic [SIZE_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ZONE_ADDR;
		pwdata  <= (DATA_W'($urandom) << SIZE_W) | DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		int unsigned phase_start;
		int unsigned run_len;
		bit          fill_run;
		bit          first_run;
		in_ch.valid        = 1'b0;
		in_ch.mode         = MODE_ALLOC;
		in_ch.request_size = '0;
		in_ch.release_slot = '0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		arst_n             = 1'b0;
		tx_idle            = 26;
		rx_idle            = 66;
		items_sent         = 0;
		zone_setting       = ZONE_RESET;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening on the reset zone of 409600 bytes
		send_item(MODE_ALLOC, 0, 0);             // first allocation after reset, offset 0
		send_item(MODE_ALLOC, SIZE_MAX, 0);      // larger than the zone: fresh zone anyway
		send_item(MODE_ALLOC, 0, 0);             // zero left, zero wanted: still fits
		send_item(MODE_ALLOC, 1, 0);             // zero left: fresh zone
		send_item(MODE_ALLOC, 100, 0);
		send_item(MODE_ALLOC, 50, 0);
		send_item(MODE_RELEASE, 0, 1);
		send_item(MODE_RELEASE, SIZE_MAX, 1);    // already released
		send_item(MODE_RELEASE, 0, 200);         // slot not in use
		send_item(MODE_RELEASE, 0, 8'hFF);       // last slot, not in use
		send_item(MODE_ALLOC, 200, 0);           // too big for the released slot
		send_item(MODE_ALLOC, 60, 0);            // reuse, slot shrinks to 60
		send_item(MODE_RELEASE, 0, 1);
		send_item(MODE_ALLOC, 61, 0);            // one byte too many for the shrunk slot
		send_item(MODE_ALLOC, 60, 0);            // exact fit
		send_item(MODE_RELEASE, 0, 0);
		send_item(MODE_RELEASE, 0, 2);
		send_item(MODE_ALLOC, 40, 0);            // first fit skips the 1-byte slot 0
		send_item(MODE_ALLOC, 1, 0);             // now slot 0 fits
		send_item(MODE_RELEASE, SIZE_MAX, 0);
		send_item(MODE_ALLOC, 2, 8'hFF);         // slot 0 too small, bump
		wait_idle(QUIET_CYCLES);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: zone_setting = SIZE_MAX;
				1: zone_setting = 19'd1;
				2: zone_setting = 19'd2500;
				3: zone_setting = ZONE_RESET;
				4: zone_setting = 19'd60000;
				default: zone_setting = SIZE_W'($urandom_range(1, SIZE_MAX));
			endcase
			// stall mix: sender light and receiver heavy, then swapped, then none
			if (phase < 2) begin
				tx_idle = 26;
				rx_idle = 66;
			end else if (phase < 4) begin
				tx_idle = 66;
				rx_idle = 26;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			write_zone_bytes(zone_setting);
			phase_start = items_sent;
			if (phase == 0) begin
				// fresh zone of the largest size left empty, then the offset saturates
				send_item(MODE_ALLOC, SIZE_MAX, 0);
				send_item(MODE_ALLOC, 0, 0);
			end
			first_run = 1'b1;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				fill_run = (first_run && zone_setting >= 100000) || $urandom_range(0, 19) == 0;
				run_len  = fill_run ? FILL_ITEMS : $urandom_range(10, 60);
				// later runs stop at the phase budget
				if (!first_run && run_len > PHASE_ITEMS - (items_sent - phase_start))
					run_len = PHASE_ITEMS - (items_sent - phase_start);
				send_run(run_len, fill_run);
				first_run = 1'b0;
			end
			wait_idle((phase == PHASES - 1) ? DRAIN_CYCLES : QUIET_CYCLES);
		end

		$display("sent %0d items over %0d zone sizes and three stall patterns",
			items_sent, PHASES + 1);
		$display("checked %0d allocations: %0d slot reuses, %0d fresh zones",
			allocs_checked, reuses_seen, fresh_seen);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
